@@ hdl/ncc_pkg.sv @@
// ----------------------------------------------------------------------------
// ncc_pkg
// Shared types and constants of the Nth-chance clock cache tag engine:
// per-entry metadata, tag layout and the controller/datapath command and
// status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package ncc_pkg;

    // default geometry and register reset value
    localparam int unsigned NUM_ENTRIES_DEF = 64;
    localparam logic [3:0]  THRESHOLD_RESET = 4'd5;

    // field widths fixed by the interface
    localparam int unsigned DEV_W   = 4;
    localparam int unsigned SEC_W   = 32;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned EIDX_W  = 6;

    // replacement metadata kept for every entry
    typedef struct packed {
        logic             valid;
        logic             accessed;
        logic             dirty;
        logic [CNT_W-1:0] count;
    } meta_t;

    // tag of one entry
    typedef struct packed {
        logic [DEV_W-1:0] device;
        logic [SEC_W-1:0] sector;
    } tag_t;

    // controller to datapath
    typedef struct packed {
        logic issue;        // read entry at address counter, advance it
        logic addr_clr;     // return address counter to entry 0
        logic clear_en;     // write reset metadata at address counter
        logic capture;      // latch request fields
        logic hit_upd;      // update hit entry and build hit result
        logic miss_direct;  // build write miss result
        logic scan_en;      // clock scan step on the staged entry
        logic load_out;     // move result into output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic match;        // staged entry holds the requested tag
        logic stage_last;   // staged entry is the last one
        logic addr_last;    // address counter at the last entry
        logic victim;       // staged entry is evicted in this scan step
        logic req_write;    // current request is a write
        logic out_free;     // output register can take a result
    } sts_t;

endpackage

`default_nettype wire

@@ hdl/ncc_ctrl.sv @@
// ----------------------------------------------------------------------------
// ncc_ctrl
// Sequencer of the tag engine: clearing pass after reset, tag lookup sweep,
// Nth-chance clock scan on a read miss and hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ncc_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire ncc_pkg::sts_t sts,
    output ncc_pkg::cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_GAP,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and datapath commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_en = 1'b1;
                cmd.issue    = 1'b1;
                if (sts.addr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                cmd.addr_clr = 1'b1;
                s_ready      = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                cmd.issue = 1'b1;
                if (sts.match) begin
                    cmd.hit_upd = 1'b1;
                    state_next  = ST_FINISH;
                end else if (sts.stage_last) begin
                    if (sts.req_write) begin
                        cmd.miss_direct = 1'b1;
                        state_next      = ST_FINISH;
                    end else begin
                        state_next = ST_GAP;
                    end
                end
            end
            ST_GAP: begin
                cmd.addr_clr = 1'b1;
                state_next   = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.issue   = 1'b1;
                cmd.scan_en = 1'b1;
                if (sts.victim) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.addr_clr = 1'b1;
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/ncc_datapath.sv @@
// ----------------------------------------------------------------------------
// ncc_datapath
// Tag and metadata memories, address counter with one read stage, tag
// compare, clock scan update, threshold register and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ncc_datapath #(
    parameter int unsigned NUM_ENTRIES = ncc_pkg::NUM_ENTRIES_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire ncc_pkg::cmd_t               cmd,
    output ncc_pkg::sts_t                    sts,
    input  wire logic                        cfg_we,
    input  wire logic [ncc_pkg::CNT_W-1:0]   cfg_wdata,
    input  wire logic                        s_opcode,
    input  wire logic [ncc_pkg::DEV_W-1:0]   s_device_id,
    input  wire logic [ncc_pkg::SEC_W-1:0]   s_sector,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_hit,
    output logic [ncc_pkg::EIDX_W-1:0]       m_entry_index,
    output logic                             m_writeback_needed,
    output logic [ncc_pkg::DEV_W-1:0]        m_victim_device,
    output logic [ncc_pkg::SEC_W-1:0]        m_victim_sector,
    output logic                             m_fill_from_disk,
    output logic                             m_write_to_disk_direct
);

    localparam int unsigned IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

    // memories
    ncc_pkg::meta_t meta_mem [NUM_ENTRIES];
    ncc_pkg::tag_t  tag_mem  [NUM_ENTRIES];

    // address counter and read stage
    logic [IDX_W-1:0]       addr_reg, addr_next;
    logic [IDX_W-1:0]       stg_idx_reg;
    logic                   stg_vld_reg;
    ncc_pkg::meta_t         meta_rd_reg;
    ncc_pkg::tag_t          tag_rd_reg;

    // request and threshold
    logic                       req_op_reg;
    logic [ncc_pkg::DEV_W-1:0]  req_dev_reg;
    logic [ncc_pkg::SEC_W-1:0]  req_sec_reg;
    logic [ncc_pkg::CNT_W-1:0]  thr_reg;

    // result under construction
    logic                        res_hit_reg;
    logic [IDX_W-1:0]            res_idx_reg;
    logic                        res_wb_reg;
    logic [ncc_pkg::DEV_W-1:0]   res_vdev_reg;
    logic [ncc_pkg::SEC_W-1:0]   res_vsec_reg;
    logic                        res_fill_reg;
    logic                        res_direct_reg;

    // output register
    logic                        m_valid_reg, m_valid_next;
    logic                        m_hit_reg;
    logic [ncc_pkg::EIDX_W-1:0]  m_idx_reg;
    logic                        m_wb_reg;
    logic [ncc_pkg::DEV_W-1:0]   m_vdev_reg;
    logic [ncc_pkg::SEC_W-1:0]   m_vsec_reg;
    logic                        m_fill_reg;
    logic                        m_direct_reg;

    // combinational helpers
    logic                        tag_eq;
    logic [ncc_pkg::CNT_W-1:0]   cnt_inc;
    logic                        victim;
    logic                        meta_we;
    logic [IDX_W-1:0]            meta_wa;
    ncc_pkg::meta_t              meta_wd;
    ncc_pkg::tag_t               tag_wd;
    logic [IDX_W+ncc_pkg::EIDX_W-1:0] idx_ext;

    // address counter: wraps after the last entry
    always_comb begin
        addr_next = addr_reg;
        if (cmd.addr_clr) begin
            addr_next = '0;
        end else if (cmd.issue) begin
            addr_next = (addr_reg == LAST_IDX) ? '0 : addr_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg    <= '0;
            stg_vld_reg <= 1'b0;
            thr_reg     <= ncc_pkg::THRESHOLD_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            addr_reg    <= addr_next;
            stg_vld_reg <= cmd.issue & ~cmd.clear_en;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                thr_reg <= cfg_wdata;
            end
        end
    end

    // registered memory reads at the address counter
    always_ff @(posedge aclk) begin
        meta_rd_reg <= meta_mem[addr_reg];
        tag_rd_reg  <= tag_mem[addr_reg];
        stg_idx_reg <= addr_reg;
    end

    // compare and clock scan decision on the staged entry
    assign tag_eq  = (tag_rd_reg.device == req_dev_reg) &&
                     (tag_rd_reg.sector == req_sec_reg);
    assign cnt_inc = meta_rd_reg.count + ncc_pkg::CNT_W'(1);
    assign victim  = stg_vld_reg & ~meta_rd_reg.accessed & (cnt_inc == thr_reg);

    // metadata write port
    always_comb begin
        meta_we = 1'b0;
        meta_wa = stg_idx_reg;
        meta_wd = meta_rd_reg;
        if (cmd.clear_en) begin
            meta_we = 1'b1;
            meta_wa = addr_reg;
            meta_wd = '0;
        end else if (cmd.hit_upd) begin
            meta_we          = 1'b1;
            meta_wd.accessed = 1'b1;
            meta_wd.dirty    = meta_rd_reg.dirty | req_op_reg;
        end else if (cmd.scan_en && stg_vld_reg) begin
            meta_we = 1'b1;
            if (meta_rd_reg.accessed) begin
                meta_wd.accessed = 1'b0;
            end else if (victim) begin
                meta_wd.valid    = 1'b1;
                meta_wd.accessed = 1'b1;
                meta_wd.dirty    = 1'b0;
                meta_wd.count    = '0;
            end else begin
                meta_wd.count = cnt_inc;
            end
        end
    end

    assign tag_wd.device = req_dev_reg;
    assign tag_wd.sector = req_sec_reg;

    // memory writes
    always_ff @(posedge aclk) begin
        if (meta_we) begin
            meta_mem[meta_wa] <= meta_wd;
        end
        if (cmd.scan_en && victim) begin
            tag_mem[stg_idx_reg] <= tag_wd;
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_op_reg  <= s_opcode;
            req_dev_reg <= s_device_id;
            req_sec_reg <= s_sector;
        end
    end

    // result build
    always_ff @(posedge aclk) begin
        if (cmd.hit_upd) begin
            res_hit_reg    <= 1'b1;
            res_idx_reg    <= stg_idx_reg;
            res_wb_reg     <= 1'b0;
            res_vdev_reg   <= '0;
            res_vsec_reg   <= '0;
            res_fill_reg   <= 1'b0;
            res_direct_reg <= 1'b0;
        end else if (cmd.miss_direct) begin
            res_hit_reg    <= 1'b0;
            res_idx_reg    <= '0;
            res_wb_reg     <= 1'b0;
            res_vdev_reg   <= '0;
            res_vsec_reg   <= '0;
            res_fill_reg   <= 1'b0;
            res_direct_reg <= 1'b1;
        end else if (cmd.scan_en && victim) begin
            res_hit_reg    <= 1'b0;
            res_idx_reg    <= stg_idx_reg;
            res_wb_reg     <= meta_rd_reg.valid & meta_rd_reg.dirty;
            res_vdev_reg   <= (meta_rd_reg.valid & meta_rd_reg.dirty) ?
                              tag_rd_reg.device : '0;
            res_vsec_reg   <= (meta_rd_reg.valid & meta_rd_reg.dirty) ?
                              tag_rd_reg.sector : '0;
            res_fill_reg   <= 1'b1;
            res_direct_reg <= 1'b0;
        end
    end

    // entry index carries the low bits of the internal index
    assign idx_ext = {{ncc_pkg::EIDX_W{1'b0}}, res_idx_reg};

    // output register
    assign m_valid_next = cmd.load_out | (m_valid_reg & ~m_ready);

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_hit_reg    <= res_hit_reg;
            m_idx_reg    <= idx_ext[ncc_pkg::EIDX_W-1:0];
            m_wb_reg     <= res_wb_reg;
            m_vdev_reg   <= res_vdev_reg;
            m_vsec_reg   <= res_vsec_reg;
            m_fill_reg   <= res_fill_reg;
            m_direct_reg <= res_direct_reg;
        end
    end

    assign m_valid                = m_valid_reg;
    assign m_hit                  = m_hit_reg;
    assign m_entry_index          = m_idx_reg;
    assign m_writeback_needed     = m_wb_reg;
    assign m_victim_device        = m_vdev_reg;
    assign m_victim_sector        = m_vsec_reg;
    assign m_fill_from_disk       = m_fill_reg;
    assign m_write_to_disk_direct = m_direct_reg;

    // status to the controller
    assign sts.match      = stg_vld_reg & meta_rd_reg.valid & tag_eq;
    assign sts.stage_last = stg_vld_reg & (stg_idx_reg == LAST_IDX);
    assign sts.addr_last  = (addr_reg == LAST_IDX);
    assign sts.victim     = victim;
    assign sts.req_write  = req_op_reg;
    assign sts.out_free   = ~m_valid_reg | m_ready;

endmodule

`default_nettype wire

@@ hdl/nth_chance_clock_cache_tags_top.sv @@
// Throughput: one request at a time; the entry-by-entry sweep over the single read port
// of the tag and metadata memories sets the rate.
// Reset: synchronous, active low; a clearing pass then zeroes the
// metadata memory while s_ready stays low. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
// nth_chance_clock_cache_tags_top
// Tag and replacement engine of a fully associative sector cache with
// Nth-chance clock replacement.
// ----------------------------------------------------------------------------
`default_nettype none

module nth_chance_clock_cache_tags_top #(
    parameter int unsigned NUM_ENTRIES = ncc_pkg::NUM_ENTRIES_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // configuration
    input  wire logic                        cfg_we,
    input  wire logic [ncc_pkg::CNT_W-1:0]   cfg_wdata,
    // request channel
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_opcode,
    input  wire logic [ncc_pkg::DEV_W-1:0]   s_device_id,
    input  wire logic [ncc_pkg::SEC_W-1:0]   s_sector,
    // result channel
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_hit,
    output logic [ncc_pkg::EIDX_W-1:0]       m_entry_index,
    output logic                             m_writeback_needed,
    output logic [ncc_pkg::DEV_W-1:0]        m_victim_device,
    output logic [ncc_pkg::SEC_W-1:0]        m_victim_sector,
    output logic                             m_fill_from_disk,
    output logic                             m_write_to_disk_direct
);

    ncc_pkg::cmd_t cmd;
    ncc_pkg::sts_t sts;

    // sequencer
    ncc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // memories and datapath
    ncc_datapath #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_datapath (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cmd                    (cmd),
        .sts                    (sts),
        .cfg_we                 (cfg_we),
        .cfg_wdata              (cfg_wdata),
        .s_opcode               (s_opcode),
        .s_device_id            (s_device_id),
        .s_sector               (s_sector),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_hit                  (m_hit),
        .m_entry_index          (m_entry_index),
        .m_writeback_needed     (m_writeback_needed),
        .m_victim_device        (m_victim_device),
        .m_victim_sector        (m_victim_sector),
        .m_fill_from_disk       (m_fill_from_disk),
        .m_write_to_disk_direct (m_write_to_disk_direct)
    );

endmodule

`default_nettype wire

@@ hdl/ncc_checker.sv @@
// ----------------------------------------------------------------------------
// ncc_checker
// Port-level checks of the tag engine: result channel stability and the
// consistency of the result flags.
// ----------------------------------------------------------------------------
`default_nettype none

module ncc_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic                        m_hit,
    input wire logic [ncc_pkg::EIDX_W-1:0]  m_entry_index,
    input wire logic                        m_writeback_needed,
    input wire logic [ncc_pkg::DEV_W-1:0]   m_victim_device,
    input wire logic [ncc_pkg::SEC_W-1:0]   m_victim_sector,
    input wire logic                        m_fill_from_disk,
    input wire logic                        m_write_to_disk_direct
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before transfer");

    // every result is exactly one of hit, fill or direct write
    a_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot({m_hit, m_fill_from_disk, m_write_to_disk_direct}))
        else $error("result kind not unique");

    // write-back only comes with a refill
    a_wb_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_writeback_needed |-> m_fill_from_disk)
        else $error("write-back without refill");

    // victim fields are zero without write-back
    a_victim_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_writeback_needed |-> m_victim_device == '0 && m_victim_sector == '0)
        else $error("victim fields set without write-back");

    // direct writes report entry zero
    a_direct_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_write_to_disk_direct |-> m_entry_index == '0)
        else $error("direct write with nonzero entry");

endmodule

bind nth_chance_clock_cache_tags_top ncc_checker u_ncc_checker (
    .aclk                   (aclk),
    .aresetn                (aresetn),
    .m_valid                (m_valid),
    .m_ready                (m_ready),
    .m_hit                  (m_hit),
    .m_entry_index          (m_entry_index),
    .m_writeback_needed     (m_writeback_needed),
    .m_victim_device        (m_victim_device),
    .m_victim_sector        (m_victim_sector),
    .m_fill_from_disk       (m_fill_from_disk),
    .m_write_to_disk_direct (m_write_to_disk_direct)
);

`default_nettype wire
